/* rtl/kvc_pkg.sv */
// Shared types, constants and the exponential table of the KV cache attention block.
package kvc_pkg;

  localparam int DATA_W      = 16;
  localparam int HEAD_OUT_W  = 3;
  localparam int POS_OUT_W   = 6;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;
  localparam int EXP_ENTRIES = 256;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_HEAD_COUNT  = 2'd0,
    REG_HEAD_LENGTH = 2'd1,
    REG_SCORE_SCALE = 2'd2
  } reg_idx_t;

  localparam logic [3:0]  HEAD_COUNT_RST  = 4'd1;
  localparam logic [6:0]  HEAD_LENGTH_RST = 7'd64;
  localparam logic [15:0] SCORE_SCALE_RST = 16'd8192;

  typedef struct packed {
    logic [3:0]  head_count;
    logic [6:0]  head_length;
    logic [15:0] score_scale;
  } cfg_t;

  typedef logic [16:0] exp_tab_t [EXP_ENTRIES];

  // exp(-i/16) in Q1.16, built by repeated multiplication in Q1.32.
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [63:0] t;
    logic [63:0] r;
    t = 64'd1 << 32;
    for (int i = 0; i < EXP_ENTRIES; i++) begin
      r      = (t + 64'd32768) >> 16;
      tab[i] = r[16:0];
      t      = (t * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

/* rtl/kvc_if.sv */
// Valid/ready channel interfaces for element input and context output.
interface kvc_in_if
  import kvc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] query_element;
  logic signed [DATA_W-1:0] key_element;
  logic signed [DATA_W-1:0] value_element;
  logic                     clear_cache;

  modport source (output valid, query_element, key_element, value_element, clear_cache,
                  input ready);
  modport sink   (input valid, query_element, key_element, value_element, clear_cache,
                  output ready);
endinterface

interface kvc_out_if
  import kvc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] context_element;
  logic [HEAD_OUT_W-1:0]    out_head;
  logic [POS_OUT_W-1:0]     out_position;
  logic                     last_of_head;
  logic                     status;

  modport source (output valid, context_element, out_head, out_position, last_of_head, status,
                  input ready);
  modport sink   (input valid, context_element, out_head, out_position, last_of_head, status,
                  output ready);
endinterface

/* rtl/kvc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/kvc_cfg.sv */
// APB register file for head count, head length and score scale.
module kvc_cfg
  import kvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_count  <= HEAD_COUNT_RST;
      cfg.head_length <= HEAD_LENGTH_RST;
      cfg.score_scale <= SCORE_SCALE_RST;
    end else if (wr) begin
      case (idx)
        REG_HEAD_COUNT:  cfg.head_count  <= pwdata[3:0];
        REG_HEAD_LENGTH: cfg.head_length <= pwdata[6:0];
        REG_SCORE_SCALE: cfg.score_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEAD_COUNT:  prdata = CFG_DW'(cfg.head_count);
      REG_HEAD_LENGTH: prdata = CFG_DW'(cfg.head_length);
      REG_SCORE_SCALE: prdata = CFG_DW'(cfg.score_scale);
      default:         prdata = '0;
    endcase
  end

endmodule

/* rtl/kvc_div.sv */
// Restoring divider, one quotient bit per cycle.
module kvc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] numer,
  input  logic [31:0] denom,
  output logic        done,
  output logic [33:0] quot
);

  logic [31:0] rem;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted = {rem, quot[33]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd34;
        rem  <= '0;
        quot <= numer;
        den  <= denom;
      end else if (busy) begin
        if (!trial[32]) begin
          rem  <= trial[31:0];
          quot <= {quot[32:0], 1'b1};
        end else begin
          rem  <= shifted[31:0];
          quot <= {quot[32:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/incremental_attention_kv_cache_unit.sv */
// Top level: decode attention over a key/value cache held in synchronous RAMs.
//
//  channel   dir  handshake        beat contents
//  in_ch     in   valid/ready      query, key, value element, clear_cache
//  out_ch    out  valid/ready      context element, head, position, last, status
//  apb       in   psel/penable     head_count @0x0, head_length @0x4, score_scale @0x8
//
// An element that does not close a head is stored and the block stays ready. The
// element that closes a head starts the head run, with N cached tokens and L
// elements per head: dot products through the one MAC, the exp pass, normalization
// on the serial divider, then the weighted value sums, plus output wait. A full
// cache skips straight to the value sums, which then come out as zero.
// Reset (rst, synchronous) clears counters and control; RAM contents stay undefined.
// A stalled output holds the beat and the run; no input is taken during a head run.
module incremental_attention_kv_cache_unit
  import kvc_pkg::*;
#(
  parameter int MAX_HEADS       = 8,
  parameter int MAX_HEAD_LENGTH = 64,
  parameter int MAX_TOKENS      = 256
) (
  input  logic              clk,
  input  logic              rst,
  kvc_in_if.sink            in_ch,
  kvc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int HD_W     = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int HCC_W    = $clog2(MAX_HEADS + 1);
  localparam int HL_W     = $clog2(MAX_HEAD_LENGTH);
  localparam int HLC_W    = $clog2(MAX_HEAD_LENGTH + 1);
  localparam int TOK_AW   = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int CNT_W    = $clog2(MAX_TOKENS + 1);
  localparam int KV_DEPTH = MAX_TOKENS * MAX_HEADS * MAX_HEAD_LENGTH;
  localparam int KV_AW    = $clog2(KV_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DOT, S_DOT_DRAIN, S_SCWR, S_EXP_RD, S_EXP_WR,
    S_NORM_RD, S_NORM_GO, S_NORM_WAIT, S_CTX, S_CTX_DRAIN, S_OUT
  } state_t;

  // Cache slot of token t, head h, element d.
  function automatic logic [KV_AW-1:0] kv_addr(input logic [TOK_AW-1:0] t,
                                                input logic [HD_W-1:0]   h,
                                                input logic [HL_W-1:0]   d);
    return KV_AW'((KV_AW'(t) * KV_AW'(MAX_HEADS) + KV_AW'(h)) * KV_AW'(MAX_HEAD_LENGTH)
                  + KV_AW'(d));
  endfunction

  cfg_t cfg;

  kvc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  state_t             state;
  logic [HL_W-1:0]    ec;
  logic [HD_W-1:0]    hc;
  logic [CNT_W-1:0]   tokens;
  logic [HD_W-1:0]    h_run;
  logic [HLC_W-1:0]   hl_run;
  logic [CNT_W-1:0]   cnt_run;
  logic               full_run;
  logic [CNT_W-1:0]   tc;
  logic [HL_W-1:0]    dc;
  logic               iss;
  logic               pv;
  logic signed [32:0] prod;
  logic signed [39:0] acc;
  logic signed [48:0] sc_prod;
  logic signed [31:0] max_sc;
  logic [31:0]        denom;

  logic               out_valid;
  logic [DATA_W-1:0]  ctx_q;
  logic [HD_W-1:0]    oh_q;
  logic [HL_W-1:0]    op_q;
  logic               ol_q;
  logic               os_q;

  // Effective configuration, clamped to the supported range.
  logic [HCC_W-1:0] hc_eff;
  logic [HLC_W-1:0] hl_eff;

  always_comb begin
    if (cfg.head_count == '0) begin
      hc_eff = HCC_W'(1);
    end else if (32'(cfg.head_count) > 32'(MAX_HEADS)) begin
      hc_eff = HCC_W'(MAX_HEADS);
    end else begin
      hc_eff = HCC_W'(cfg.head_count);
    end
    if (cfg.head_length == '0) begin
      hl_eff = HLC_W'(1);
    end else if (32'(cfg.head_length) > 32'(MAX_HEAD_LENGTH)) begin
      hl_eff = HLC_W'(MAX_HEAD_LENGTH);
    end else begin
      hl_eff = HLC_W'(cfg.head_length);
    end
  end

  // Input beat decode.
  logic             in_acc;
  logic             clr;
  logic [CNT_W-1:0] tok_now;
  logic             full_now;
  logic             head_end;
  logic             tok_end;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign clr         = in_ch.clear_cache && (ec == '0) && (hc == '0);
  assign tok_now     = clr ? '0 : tokens;
  assign full_now    = (tok_now >= CNT_W'(MAX_TOKENS));
  assign head_end    = (HLC_W'(ec) + HLC_W'(1)) >= hl_eff;
  assign tok_end     = (HCC_W'(hc) + HCC_W'(1)) >= hc_eff;

  // Memories.
  logic [DATA_W-1:0] q_rd;
  logic [DATA_W-1:0] k_rd;
  logic [DATA_W-1:0] v_rd;
  logic [31:0]       s_rd;
  logic [KV_AW-1:0]  kv_waddr;
  logic [KV_AW-1:0]  kv_raddr;
  logic              kv_we;
  logic              s_we;
  logic [31:0]       s_wd;

  assign kv_we    = in_acc && !full_now;
  assign kv_waddr = kv_addr(tok_now[TOK_AW-1:0], hc, ec);
  assign kv_raddr = kv_addr(tc[TOK_AW-1:0], h_run, dc);

  kvc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_HEAD_LENGTH)) u_query_buf (
    .clk, .we(in_acc), .waddr(ec), .wdata(in_ch.query_element),
    .raddr(dc), .rdata(q_rd)
  );

  kvc_ram #(.WIDTH(DATA_W), .DEPTH(KV_DEPTH)) u_key_store (
    .clk, .we(kv_we), .waddr(kv_waddr), .wdata(in_ch.key_element),
    .raddr(kv_raddr), .rdata(k_rd)
  );

  kvc_ram #(.WIDTH(DATA_W), .DEPTH(KV_DEPTH)) u_value_store (
    .clk, .we(kv_we), .waddr(kv_waddr), .wdata(in_ch.value_element),
    .raddr(kv_raddr), .rdata(v_rd)
  );

  kvc_ram #(.WIDTH(32), .DEPTH(MAX_TOKENS)) u_score_buf (
    .clk, .we(s_we), .waddr(tc[TOK_AW-1:0]), .wdata(s_wd),
    .raddr(tc[TOK_AW-1:0]), .rdata(s_rd)
  );

  // Shared MAC: q*k (floor >> 8) for scores, weight*value for context sums.
  logic               ctx_mode;
  logic signed [16:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [39:0] term;

  assign ctx_mode = (state == S_CTX) || (state == S_CTX_DRAIN);
  assign mul_a    = ctx_mode ? $signed({1'b0, s_rd[15:0]}) : $signed({q_rd[15], q_rd});
  assign mul_b    = ctx_mode ? $signed(v_rd) : $signed(k_rd);
  assign term     = ctx_mode ? {{7{prod[32]}}, prod} : {{15{prod[32]}}, prod[32:8]};

  // Scaled score, exp term, normalization operands.
  logic signed [31:0] sc;
  logic signed [32:0] diff;
  logic [16:0]        exp_term;
  logic [33:0]        numer;
  logic               div_start;
  logic               div_done;
  logic [33:0]        quot;
  logic [15:0]        weight;

  assign sc        = sc_prod[47:16];
  assign diff      = $signed({max_sc[31], max_sc}) - $signed({s_rd[31], s_rd});
  assign exp_term  = (|diff[32:12]) ? '0 : EXP_TABLE[diff[11:4]];
  assign numer     = {1'b0, s_rd[16:0], 16'd0} + 34'(denom >> 1);
  assign div_start = (state == S_NORM_GO);
  assign weight    = (|quot[33:16]) ? 16'hFFFF : quot[15:0];

  kvc_div u_div (
    .clk, .rst, .start(div_start), .numer, .denom, .done(div_done), .quot
  );

  always_comb begin
    s_we = 1'b0;
    s_wd = '0;
    case (state)
      S_SCWR: begin
        s_we = 1'b1;
        s_wd = sc;
      end
      S_EXP_WR: begin
        s_we = 1'b1;
        s_wd = 32'(exp_term);
      end
      S_NORM_WAIT: begin
        s_we = div_done;
        s_wd = 32'(weight);
      end
      default: ;
    endcase
  end

  // Rounded, saturated context element.
  logic signed [39:0] rnd;
  logic [DATA_W-1:0]  ctx_val;

  assign rnd     = acc + 40'sd32768;
  assign ctx_val = ((rnd[39:31] == '0) || (rnd[39:31] == '1)) ? rnd[31:16]
                 : (rnd[39] ? 16'h8000 : 16'h7FFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ec        <= '0;
      hc        <= '0;
      tokens    <= '0;
      iss       <= 1'b0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // MAC pipeline: RAM read, product, accumulate.
      iss <= (state == S_DOT) || ((state == S_CTX) && (cnt_run != '0));
      pv  <= iss;
      if (iss) begin
        prod <= mul_a * mul_b;
      end
      if (pv) begin
        acc <= acc + term;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            tokens <= tok_now;
            if (head_end) begin
              h_run    <= hc;
              hl_run   <= hl_eff;
              full_run <= full_now;
              cnt_run  <= full_now ? '0 : tok_now + CNT_W'(1);
              ec       <= '0;
              tc       <= '0;
              dc       <= '0;
              acc      <= '0;
              max_sc   <= 32'sh8000_0000;
              if (tok_end) begin
                hc <= '0;
                if (!full_now) begin
                  tokens <= tok_now + CNT_W'(1);
                end
              end else begin
                hc <= hc + HD_W'(1);
              end
              state <= full_now ? S_CTX : S_DOT;
            end else begin
              ec <= ec + HL_W'(1);
            end
          end
        end
        S_DOT: begin
          if (HLC_W'(dc) + HLC_W'(1) == hl_run) begin
            dc    <= '0;
            state <= S_DOT_DRAIN;
          end else begin
            dc <= dc + HL_W'(1);
          end
        end
        S_DOT_DRAIN: begin
          if (!iss && !pv) begin
            sc_prod <= $signed(acc[31:0]) * $signed({1'b0, cfg.score_scale});
            state   <= S_SCWR;
          end
        end
        S_SCWR: begin
          if (sc > max_sc) begin
            max_sc <= sc;
          end
          acc <= '0;
          if (tc + CNT_W'(1) == cnt_run) begin
            tc    <= '0;
            denom <= '0;
            state <= S_EXP_RD;
          end else begin
            tc    <= tc + CNT_W'(1);
            state <= S_DOT;
          end
        end
        S_EXP_RD: begin
          state <= S_EXP_WR;
        end
        S_EXP_WR: begin
          denom <= denom + 32'(exp_term);
          if (tc + CNT_W'(1) == cnt_run) begin
            tc    <= '0;
            state <= S_NORM_RD;
          end else begin
            tc    <= tc + CNT_W'(1);
            state <= S_EXP_RD;
          end
        end
        S_NORM_RD: begin
          state <= S_NORM_GO;
        end
        S_NORM_GO: begin
          state <= S_NORM_WAIT;
        end
        S_NORM_WAIT: begin
          if (div_done) begin
            if (tc + CNT_W'(1) == cnt_run) begin
              tc    <= '0;
              dc    <= '0;
              acc   <= '0;
              state <= S_CTX;
            end else begin
              tc    <= tc + CNT_W'(1);
              state <= S_NORM_RD;
            end
          end
        end
        S_CTX: begin
          if ((cnt_run == '0) || (tc + CNT_W'(1) == cnt_run)) begin
            state <= S_CTX_DRAIN;
          end else begin
            tc <= tc + CNT_W'(1);
          end
        end
        S_CTX_DRAIN: begin
          if (!iss && !pv) begin
            ctx_q     <= ctx_val;
            oh_q      <= h_run;
            op_q      <= dc;
            ol_q      <= (HLC_W'(dc) + HLC_W'(1) == hl_run);
            os_q      <= full_run;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            tc        <= '0;
            acc       <= '0;
            if (ol_q) begin
              state <= S_IDLE;
            end else begin
              dc    <= dc + HL_W'(1);
              state <= S_CTX;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.context_element = ctx_q;
  assign out_ch.out_head        = HEAD_OUT_W'(oh_q);
  assign out_ch.out_position    = POS_OUT_W'(op_q);
  assign out_ch.last_of_head    = ol_q;
  assign out_ch.status          = os_q;

  // Input and output never overlap: a head run owns the block.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken during a head run");

  // A token that was not stored yields zero sums.
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status) |-> (out_ch.context_element == '0))
    else $error("cache-full beat carries a nonzero context");

  // Cache fill count stays within capacity.
  a_tokens_cap: assert property (@(posedge clk) disable iff (rst)
    tokens <= CNT_W'(MAX_TOKENS))
    else $error("token count beyond capacity");

  // The last beat of a head returns the block to input.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_of_head) |=> in_ch.ready)
    else $error("block not idle after last beat of head");

endmodule

/* tb/tb_incremental_attention_kv_cache_unit.sv */
// Testbench of the KV cache decode attention block: directed and random tokens, checked beat by beat.
module tb_incremental_attention_kv_cache_unit;
  import kvc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEADS_MAX   = 8;
  localparam int LENGTH_MAX  = 64;
  localparam int TOKENS_MAX  = 256;
  localparam int STORE_WORDS = TOKENS_MAX * HEADS_MAX * LENGTH_MAX;

  // Idle modes of the two channels.
  localparam int MODE_BUSY      = 0;
  localparam int MODE_SRC_IDLE  = 1;
  localparam int MODE_SNK_STALL = 2;
  localparam int MODE_BOTH      = 3;

  // Value patterns of a token.
  localparam int PAT_RANDOM = 0;
  localparam int PAT_MAX    = 1;
  localparam int PAT_MIN    = 2;
  localparam int PAT_ALT    = 3;

  typedef struct packed {
    logic signed [15:0] context_element;
    logic [2:0]         out_head;
    logic [5:0]         out_position;
    logic               last_of_head;
    logic               status;
  } context_beat_t;

  // Predicts the context beats of each head run and checks the beats that come out.
  class context_predictor;
    logic [3:0]         head_count;
    logic [6:0]         head_length;
    logic [15:0]        score_scale;
    logic signed [15:0] key_mem [STORE_WORDS];
    logic signed [15:0] val_mem [STORE_WORDS];
    logic signed [15:0] query_mem [LENGTH_MAX];
    int unsigned        exp_lut [256];
    int unsigned        tokens_held;
    int unsigned        elem_idx;
    int unsigned        head_idx;
    context_beat_t      expected_context [$];
    int                 errors;

    function new();
      longint unsigned t;
      t = 64'd1 << 32;
      for (int i = 0; i < 256; i++) begin
        exp_lut[i] = int'((t + 64'd32768) >> 16);
        t = (t * 64'd4034748382 + (64'd1 << 31)) >> 32;
      end
      head_count  = HEAD_COUNT_RST;
      head_length = HEAD_LENGTH_RST;
      score_scale = SCORE_SCALE_RST;
      tokens_held = 0;
      elem_idx    = 0;
      head_idx    = 0;
      errors      = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned token_beats();
      return clamp(head_count, HEADS_MAX) * clamp(head_length, LENGTH_MAX);
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_HEAD_COUNT:  head_count  = val[3:0];
        REG_HEAD_LENGTH: head_length = val[6:0];
        REG_SCORE_SCALE: score_scale = val[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned addr(int unsigned t, int unsigned h, int unsigned d);
      return (t * HEADS_MAX + h) * LENGTH_MAX + d;
    endfunction

    // Score, softmax and weighted value sums of one head.
    function void run_head(int unsigned h, int unsigned hl, bit full);
      int unsigned     count;
      int              score [TOKENS_MAX];
      longint unsigned weight [TOKENS_MAX];
      int              best;
      int              acc;
      longint          wide;
      longint          diff;
      longint unsigned denom;
      context_beat_t   beat;
      count = full ? 0 : tokens_held + 1;
      best  = 32'sh8000_0000;
      denom = 0;
      for (int unsigned t = 0; t < count; t++) begin
        acc = 0;
        for (int unsigned d = 0; d < hl; d++) begin
          wide = longint'(query_mem[d]) * longint'(key_mem[addr(t, h, d)]);
          acc += int'(wide >>> 8);
        end
        wide = longint'(acc) * longint'({48'd0, score_scale});
        score[t] = int'(wide >>> 16);
        if (score[t] > best) best = score[t];
      end
      for (int unsigned t = 0; t < count; t++) begin
        diff = (longint'(best) - longint'(score[t])) >>> 4;
        weight[t] = (diff >= 256) ? 0 : exp_lut[int'(diff)];
        denom += weight[t];
      end
      for (int unsigned t = 0; t < count; t++) begin
        weight[t] = (weight[t] * 65536 + denom / 2) / denom;
        if (weight[t] > 65535) weight[t] = 65535;
      end
      for (int unsigned d = 0; d < hl; d++) begin
        wide = 0;
        if (!full) begin
          for (int unsigned t = 0; t < count; t++)
            wide += longint'(weight[t]) * longint'(val_mem[addr(t, h, d)]);
          wide = (wide + 32768) >>> 16;
          if (wide > 32767) wide = 32767;
          if (wide < -32768) wide = -32768;
        end
        beat.context_element = wide[15:0];
        beat.out_head        = h[2:0];
        beat.out_position    = d[5:0];
        beat.last_of_head    = (d + 1 == hl);
        beat.status          = full;
        expected_context     = {expected_context, beat};
      end
    endfunction

    // Store one accepted input beat and advance the element and head counters; a beat that closes a head runs it.
    function void note_element(logic signed [15:0] q, logic signed [15:0] k,
                               logic signed [15:0] v, logic clr);
      int unsigned hc;
      int unsigned hl;
      int unsigned e;
      int unsigned h;
      bit          full;
      hc = clamp(head_count, HEADS_MAX);
      hl = clamp(head_length, LENGTH_MAX);
      e  = (elem_idx >= LENGTH_MAX) ? LENGTH_MAX - 1 : elem_idx;
      h  = (head_idx >= HEADS_MAX) ? HEADS_MAX - 1 : head_idx;
      if (clr && elem_idx == 0 && head_idx == 0) tokens_held = 0;
      full = (tokens_held >= TOKENS_MAX);
      query_mem[e] = q;
      if (!full) begin
        key_mem[addr(tokens_held, h, e)] = k;
        val_mem[addr(tokens_held, h, e)] = v;
      end
      if (e + 1 >= hl) begin
        run_head(h, hl, full);
        elem_idx = 0;
        if (h + 1 >= hc) begin
          head_idx = 0;
          if (!full) tokens_held++;
        end else begin
          head_idx = h + 1;
        end
      end else begin
        elem_idx = e + 1;
      end
    endfunction

    function void compare(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_context(context_beat_t act);
      context_beat_t exp_b;
      if (expected_context.size() == 0) begin
        $display("%0t: unexpected beat, actual %p", $time, act);
        errors++;
        return;
      end
      exp_b = expected_context.pop_front();
      compare("context_element", exp_b.context_element, act.context_element);
      compare("out_head", exp_b.out_head, act.out_head);
      compare("out_position", exp_b.out_position, act.out_position);
      compare("last_of_head", exp_b.last_of_head, act.last_of_head);
      compare("status", exp_b.status, act.status);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  kvc_in_if  in_ch ();
  kvc_out_if out_ch ();

  incremental_attention_kv_cache_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  context_predictor predictor = new();
  int idle_mode  = MODE_BUSY;
  bit need_clear = 1'b1;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Drive ready at the falling edge, stalling as the current mode asks.
  always @(negedge clk) begin
    case (idle_mode)
      MODE_SNK_STALL: out_ch.ready <= ($urandom_range(99) >= 64);
      MODE_BOTH:      out_ch.ready <= ($urandom_range(99) >= 38);
      default:        out_ch.ready <= 1'b1;
    endcase
  end

  // Check every output beat at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      predictor.check_context({out_ch.context_element, out_ch.out_head,
                               out_ch.out_position, out_ch.last_of_head, out_ch.status});
  end

  // Write one register through the setup and access phases.
  task automatic write_cfg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_AW'(idx) << 2;
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    predictor.write_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    need_clear = 1'b1;
  endtask

  task automatic set_shape(logic [31:0] hc, logic [31:0] hl, logic [31:0] scale);
    write_cfg(REG_HEAD_COUNT, hc);
    write_cfg(REG_HEAD_LENGTH, hl);
    write_cfg(REG_SCORE_SCALE, scale);
  endtask

  // Hold until all expected beats are out, then let the block settle.
  task automatic drain();
    while (predictor.expected_context.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Send one input beat; valid drops after the beat is taken and stays low while the sender idles.
  task automatic send_element(logic [15:0] q, logic [15:0] k, logic [15:0] v, logic clr);
    int pct;
    pct = (idle_mode == MODE_SRC_IDLE) ? 64 : (idle_mode == MODE_BOTH) ? 38 : 0;
    while ($urandom_range(99) < pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.query_element = q;
    in_ch.key_element   = k;
    in_ch.value_element = v;
    in_ch.clear_cache   = clr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predictor.note_element(q, k, v, clr);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Send a whole token; clear_cache is random past the first beat, where it is ignored.
  task automatic send_token(int pat, bit clr);
    int unsigned n;
    logic [15:0] q, k, v;
    n = predictor.token_beats();
    for (int unsigned i = 0; i < n; i++) begin
      case (pat)
        PAT_MAX: begin q = 16'h7fff; k = 16'h7fff; v = 16'h7fff; end
        PAT_MIN: begin q = 16'h8000; k = 16'h8000; v = 16'h8000; end
        PAT_ALT: begin
          q = i[0] ? 16'h8000 : 16'h7fff;
          k = q;
          v = ~q;
        end
        default: begin q = 16'($urandom); k = 16'($urandom); v = 16'($urandom); end
      endcase
      send_element(q, k, v, (i == 0) ? (clr | need_clear) : 1'($urandom_range(1)));
    end
    need_clear = 1'b0;
  endtask

  initial begin
    int sent;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.query_element = '0;
    in_ch.key_element   = '0;
    in_ch.value_element = '0;
    in_ch.clear_cache   = 1'b0;
    out_ch.ready        = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extremes of the element fields at full score scale.
    set_shape(1, 4, 65535);
    send_token(PAT_MAX, 1'b1);
    send_token(PAT_MIN, 1'b0);
    send_token(PAT_ALT, 1'b0);
    drain();

    // Zero scale, out-of-range registers clamp to one head of one element; fill the
    // cache, then two tokens land on a full cache and return status only.
    set_shape(0, 0, 0);
    for (int i = 0; i < TOKENS_MAX + 2; i++) send_token(PAT_RANDOM, 1'b0);
    send_token(PAT_RANDOM, 1'b1);
    drain();

    // Register values above range clamp to the largest shapes.
    set_shape(15, 1, 20000);
    send_token(PAT_RANDOM, 1'b0);
    send_token(PAT_RANDOM, 1'b0);
    drain();
    set_shape(1, 127, 8192);
    send_token(PAT_RANDOM, 1'b0);
    send_token(PAT_RANDOM, 1'b0);
    drain();

    // Shrink head_length mid-head: the next beat closes the head.
    set_shape(2, 8, 12000);
    for (int i = 0; i < 5; i++)
      send_element(16'($urandom), 16'($urandom), 16'($urandom), i == 0);
    drain();
    write_cfg(REG_HEAD_LENGTH, 3);
    for (int i = 0; i < 4; i++)
      send_element(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    drain();
    // Shrink head_count mid-token: the next head ends the token.
    write_cfg(REG_HEAD_COUNT, 4);
    for (int i = 0; i < 3; i++)
      send_element(16'($urandom), 16'($urandom), 16'($urandom), i == 0);
    drain();
    write_cfg(REG_HEAD_COUNT, 1);
    for (int i = 0; i < 3; i++)
      send_element(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    drain();

    // Random tokens, one idle mode per phase, reshaped halfway through each.
    for (int mode = MODE_BUSY; mode <= MODE_BOTH; mode++) begin
      idle_mode = mode;
      for (int half = 0; half < 2; half++) begin
        set_shape($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(65535));
        sent = 0;
        while (sent < 19) begin
          sent += predictor.token_beats();
          send_token(PAT_RANDOM, $urandom_range(3) == 0);
          // Pause the sender once until the block has emptied.
          if (mode == MODE_SNK_STALL && half == 0 && sent <= predictor.token_beats())
            while (predictor.expected_context.size() != 0) @(negedge clk);
        end
        drain();
      end
    end

    idle_mode = MODE_BUSY;
    drain();
    repeat (100) @(negedge clk);
    if (predictor.errors == 0 && predictor.expected_context.size() == 0) begin
      $display("tb_incremental_attention_kv_cache_unit OK");
    end else begin
      $display("tb_incremental_attention_kv_cache_unit NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #360_000_000;
    $display("tb_incremental_attention_kv_cache_unit NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/kvc_pkg.sv
rtl/kvc_if.sv
rtl/kvc_ram.sv
rtl/kvc_cfg.sv
rtl/kvc_div.sv
rtl/incremental_attention_kv_cache_unit.sv
tb/tb_incremental_attention_kv_cache_unit.sv
